// ===== sv/ssd_pkg.sv =====
`default_nettype none
package ssd_pkg;

    localparam int COORD_W     = 32;
    localparam int DIFF_W      = 33;
    localparam int PROD_W      = 66;
    localparam int DOT_W       = 68;
    localparam int WIDE_W      = 136;
    localparam int DIV_W       = 135;
    localparam int FRAC_W      = 32;
    localparam int Q_W         = 33;
    localparam int PVEC_W      = 68;
    localparam int SQ_W        = 134;
    localparam int ROOT_W      = 67;
    localparam int DIST_W      = 33;
    localparam int LIM_W       = 16;
    localparam int FIFO_DEPTH  = 4;
    localparam int DIV_STAGES  = Q_W;
    localparam int SQRT_STAGES = ROOT_W;
    localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(1);

    typedef logic signed [DIFF_W-1:0] t_diff;

    // Direction vectors and start offset of one segment pair
    typedef struct packed {
        t_diff [2:0] u;
        t_diff [2:0] v;
        t_diff [2:0] w;
    } t_item;

endpackage
`default_nettype wire

// ===== sv/ssd_if.sv =====
`default_nettype none
interface ssd_in_if;
    import ssd_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] first_start_x;
    logic [COORD_W-1:0] first_start_y;
    logic [COORD_W-1:0] first_start_z;
    logic [COORD_W-1:0] first_end_x;
    logic [COORD_W-1:0] first_end_y;
    logic [COORD_W-1:0] first_end_z;
    logic [COORD_W-1:0] second_start_x;
    logic [COORD_W-1:0] second_start_y;
    logic [COORD_W-1:0] second_start_z;
    logic [COORD_W-1:0] second_end_x;
    logic [COORD_W-1:0] second_end_y;
    logic [COORD_W-1:0] second_end_z;

    modport source (
        output valid, first_start_x, first_start_y, first_start_z,
               first_end_x, first_end_y, first_end_z,
               second_start_x, second_start_y, second_start_z,
               second_end_x, second_end_y, second_end_z,
        input  ready
    );
    modport sink (
        input  valid, first_start_x, first_start_y, first_start_z,
               first_end_x, first_end_y, first_end_z,
               second_start_x, second_start_y, second_start_z,
               second_end_x, second_end_y, second_end_z,
        output ready
    );
endinterface

interface ssd_out_if;
    import ssd_pkg::*;
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] closest_distance;

    modport source (output valid, closest_distance, input ready);
    modport sink   (input valid, closest_distance, output ready);
endinterface
`default_nettype wire

// ===== sv/ssd_front.sv =====
`default_nettype none
module ssd_front #(
    parameter int COORD_BITS = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    ssd_in_if.sink              i_in,
    output logic                o_valid,
    output ssd_pkg::t_item      o_item,
    input  wire logic           i_take
);
    import ssd_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    function automatic t_diff ext(input logic [COORD_W-1:0] raw);
        ext = {{(DIFF_W-COORD_BITS){raw[COORD_BITS-1]}}, raw[COORD_BITS-1:0]};
    endfunction

    always_comb begin
        n_item.u[0] = ext(i_in.first_end_x) - ext(i_in.first_start_x);
        n_item.u[1] = ext(i_in.first_end_y) - ext(i_in.first_start_y);
        n_item.u[2] = ext(i_in.first_end_z) - ext(i_in.first_start_z);
        n_item.v[0] = ext(i_in.second_end_x) - ext(i_in.second_start_x);
        n_item.v[1] = ext(i_in.second_end_y) - ext(i_in.second_start_y);
        n_item.v[2] = ext(i_in.second_end_z) - ext(i_in.second_start_z);
        n_item.w[0] = ext(i_in.first_start_x) - ext(i_in.second_start_x);
        n_item.w[1] = ext(i_in.first_start_y) - ext(i_in.second_start_y);
        n_item.w[2] = ext(i_in.first_start_z) - ext(i_in.second_start_z);
    end

    assign i_in.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_item <= n_item;
        end
    end
endmodule
`default_nettype wire

// ===== sv/ssd_fifo.sv =====
`default_nettype none
module ssd_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  ssd_pkg::t_item      i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output ssd_pkg::t_item      o_data,
    output logic                o_empty
);
    import ssd_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_item             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end
endmodule
`default_nettype wire

// ===== sv/ssd_div.sv =====
`default_nettype none
module ssd_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [ssd_pkg::DIV_W-1:0] i_num,
    input  wire logic [ssd_pkg::DIV_W-1:0] i_den,
    input  wire logic                     i_zero,
    output logic      [ssd_pkg::Q_W-1:0]   o_quot
);
    import ssd_pkg::*;

    logic [DIV_W-1:0] r_rem  [DIV_STAGES];
    logic [DIV_W-1:0] r_den  [DIV_STAGES];
    logic [Q_W-1:0]   r_q    [DIV_STAGES];
    logic             r_zero [DIV_STAGES];

    // Top quotient bit: numerator never exceeds the divisor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]  <= i_den;
            r_zero[0] <= i_zero;
            if (i_num == i_den) begin
                r_rem[0] <= '0;
                r_q[0]   <= Q_W'(1);
            end else begin
                r_rem[0] <= i_num;
                r_q[0]   <= '0;
            end
        end
    end

    for (genvar j = 1; j < DIV_STAGES; j++) begin : g_stage
        logic [DIV_W:0] n_two;
        logic [DIV_W:0] n_diff;
        logic           n_ge;

        assign n_two  = {r_rem[j-1], 1'b0};
        assign n_diff = n_two - {1'b0, r_den[j-1]};
        assign n_ge   = (n_two >= {1'b0, r_den[j-1]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[j]  <= r_den[j-1];
                r_zero[j] <= r_zero[j-1];
                r_q[j]    <= {r_q[j-1][Q_W-2:0], n_ge};
                r_rem[j]  <= n_ge ? n_diff[DIV_W-1:0] : n_two[DIV_W-1:0];
            end
        end
    end

    assign o_quot = r_zero[DIV_STAGES-1] ? '0 : r_q[DIV_STAGES-1];
endmodule
`default_nettype wire

// ===== sv/ssd_sqrt.sv =====
`default_nettype none
module ssd_sqrt (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [ssd_pkg::SQ_W-1:0]   i_sq,
    output logic      [ssd_pkg::ROOT_W-1:0] o_root
);
    import ssd_pkg::*;

    logic [SQ_W-1:0]   r_rem  [SQRT_STAGES];
    logic [ROOT_W-1:0] r_root [SQRT_STAGES];

    for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
        localparam int K = ROOT_W - 1 - i;
        logic [SQ_W-1:0]   n_rem_in;
        logic [ROOT_W-1:0] n_root_in;
        logic [SQ_W:0]     n_trial;
        logic [SQ_W:0]     n_left;
        logic              n_take;

        if (i == 0) begin : g_first
            assign n_rem_in  = i_sq;
            assign n_root_in = '0;
        end else begin : g_next
            assign n_rem_in  = r_rem[i-1];
            assign n_root_in = r_root[i-1];
        end

        // (root + 2^K)^2 - root^2 = root * 2^(K+1) + 2^(2K)
        assign n_trial = (((SQ_W+1)'(n_root_in)) << (K + 1))
                       + (((SQ_W+1)'(1)) << (2 * K));
        assign n_take  = ({1'b0, n_rem_in} >= n_trial);
        assign n_left  = {1'b0, n_rem_in} - n_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i]  <= n_take ? n_left[SQ_W-1:0] : n_rem_in;
                r_root[i] <= n_take ? (n_root_in | (ROOT_W'(1) << K)) : n_root_in;
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];
endmodule
`default_nettype wire

// ===== sv/ssd_back.sv =====
`default_nettype none
module ssd_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [ssd_pkg::LIM_W-1:0]  i_lim,
    input  wire logic                      i_empty,
    input  ssd_pkg::t_item                 i_item,
    output logic                           o_pop,
    ssd_out_if.source                      o_out
);
    import ssd_pkg::*;

    localparam int HALF_W = DOT_W / 2;

    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic signed [DOT_W-1:0]  t_dot;

    // partial products of one wide multiply, split at HALF_W
    typedef struct packed {
        logic [2*HALF_W-1:0] hh;
        logic [2*HALF_W:0]   hl;
        logic [2*HALF_W:0]   lh;
        logic [2*HALF_W-1:0] ll;
    } t_part;

    function automatic t_part part_mul(input t_dot x, input t_dot y);
        t_part r;
        r.hh = $signed(x[DOT_W-1:HALF_W]) * $signed(y[DOT_W-1:HALF_W]);
        r.hl = $signed(x[DOT_W-1:HALF_W]) * $signed({1'b0, y[HALF_W-1:0]});
        r.lh = $signed({1'b0, x[HALF_W-1:0]}) * $signed(y[DOT_W-1:HALF_W]);
        r.ll = x[HALF_W-1:0] * y[HALF_W-1:0];
        return r;
    endfunction

    function automatic t_wide part_sum(input t_part pp);
        return (WIDE_W'($signed(pp.hh)) <<< (2 * HALF_W))
             + (WIDE_W'($signed(pp.hl)) <<< HALF_W)
             + (WIDE_W'($signed(pp.lh)) <<< HALF_W)
             + WIDE_W'(pp.ll);
    endfunction

    logic en;
    assign en    = !o_out.valid || o_out.ready;
    assign o_pop = en && !i_empty;

    t_wide n_lim;
    assign n_lim = WIDE_W'(i_lim);

    // dot products: a = u.u, b = u.v, c = v.v, d = u.w, e = v.w
    logic                     r_v1;
    t_item                    r_it1;
    logic signed [PROD_W-1:0] r_pp [5][3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it1 <= i_item;
            for (int i = 0; i < 3; i++) begin
                r_pp[0][i] <= $signed(i_item.u[i]) * $signed(i_item.u[i]);
                r_pp[1][i] <= $signed(i_item.u[i]) * $signed(i_item.v[i]);
                r_pp[2][i] <= $signed(i_item.v[i]) * $signed(i_item.v[i]);
                r_pp[3][i] <= $signed(i_item.u[i]) * $signed(i_item.w[i]);
                r_pp[4][i] <= $signed(i_item.v[i]) * $signed(i_item.w[i]);
            end
        end
    end

    logic  r_v2;
    t_item r_it2;
    t_dot  r_dot2 [5];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it2 <= r_it1;
            for (int k = 0; k < 5; k++) begin
                r_dot2[k] <= DOT_W'(r_pp[k][0]) + DOT_W'(r_pp[k][1]) + DOT_W'(r_pp[k][2]);
            end
        end
    end

    // second-order products: partial products first, then their sum
    logic  r_v3;
    t_item r_it3;
    t_dot  r_dot3 [5];
    t_part r_pt3 [6];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it3    <= r_it2;
            r_dot3   <= r_dot2;
            r_pt3[0] <= part_mul(r_dot2[0], r_dot2[2]);
            r_pt3[1] <= part_mul(r_dot2[1], r_dot2[1]);
            r_pt3[2] <= part_mul(r_dot2[1], r_dot2[4]);
            r_pt3[3] <= part_mul(r_dot2[2], r_dot2[3]);
            r_pt3[4] <= part_mul(r_dot2[0], r_dot2[4]);
            r_pt3[5] <= part_mul(r_dot2[1], r_dot2[3]);
        end
    end

    logic  r_vpr;
    t_item r_itpr;
    t_dot  r_dotpr [5];
    t_wide r_ac, r_bb, r_be, r_cd, r_ae, r_bd;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_itpr  <= r_it3;
            r_dotpr <= r_dot3;
            r_ac    <= part_sum(r_pt3[0]);
            r_bb    <= part_sum(r_pt3[1]);
            r_be    <= part_sum(r_pt3[2]);
            r_cd    <= part_sum(r_pt3[3]);
            r_ae    <= part_sum(r_pt3[4]);
            r_bd    <= part_sum(r_pt3[5]);
        end
    end

    logic  r_v4;
    t_item r_it4;
    t_dot  r_dot4 [5];
    t_wide r_dd4, r_sn4, r_tn4;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it4  <= r_itpr;
            r_dot4 <= r_dotpr;
            r_dd4  <= r_ac - r_bb;
            r_sn4  <= r_be - r_cd;
            r_tn4  <= r_ae - r_bd;
        end
    end

    // first classification: near parallel, then s edge clamp
    logic  r_v5;
    t_item r_it5;
    t_wide r_a5, r_b5, r_d5;
    t_wide r_sn5, r_sd5, r_tn5, r_td5;
    t_wide n_sn5, n_sd5, n_tn5, n_td5;
    t_wide n_b4, n_c4, n_e4;

    always_comb begin
        n_b4  = WIDE_W'(r_dot4[1]);
        n_c4  = WIDE_W'(r_dot4[2]);
        n_e4  = WIDE_W'(r_dot4[4]);
        n_sd5 = r_dd4;
        n_td5 = r_dd4;
        if (r_dd4 < n_lim) begin
            n_sn5 = '0;
            n_sd5 = WIDE_W'(1);
            n_tn5 = n_e4;
            n_td5 = n_c4;
        end else begin
            n_sn5 = r_sn4;
            n_tn5 = r_tn4;
            if (r_sn4 < 0) begin
                n_sn5 = '0;
                n_tn5 = n_e4;
                n_td5 = n_c4;
            end else if (r_dd4 < r_sn4) begin
                n_sn5 = r_dd4;
                n_tn5 = n_e4 + n_b4;
                n_td5 = n_c4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it5 <= r_it4;
            r_a5  <= WIDE_W'(r_dot4[0]);
            r_b5  <= n_b4;
            r_d5  <= WIDE_W'(r_dot4[3]);
            r_sn5 <= n_sn5;
            r_sd5 <= n_sd5;
            r_tn5 <= n_tn5;
            r_td5 <= n_td5;
        end
    end

    // t edge clamp and recompute of s
    logic  r_v6;
    t_item r_it6;
    t_wide r_sn6, r_sd6, r_tn6, r_td6;
    t_wide n_sn6, n_sd6, n_tn6, n_m;
    logic  n_fix;

    always_comb begin
        n_sn6 = r_sn5;
        n_sd6 = r_sd5;
        n_tn6 = r_tn5;
        n_m   = '0;
        n_fix = 1'b1;
        if (r_tn5 < 0) begin
            n_tn6 = '0;
            n_m   = -r_d5;
        end else if (r_td5 < r_tn5) begin
            n_tn6 = r_td5;
            n_m   = r_b5 - r_d5;
        end else begin
            n_fix = 1'b0;
        end
        if (n_fix) begin
            if (n_m < 0) begin
                n_sn6 = '0;
            end else if (r_a5 < n_m) begin
                n_sn6 = r_sd5;
            end else begin
                n_sn6 = n_m;
                n_sd6 = r_a5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it6 <= r_it5;
            r_sn6 <= n_sn6;
            r_sd6 <= n_sd6;
            r_tn6 <= n_tn6;
            r_td6 <= r_td5;
        end
    end

    // ratio set-up: zero flags and numerator clamp
    logic             r_v7;
    t_item            r_it7;
    logic [DIV_W-1:0] r_sn7, r_sd7, r_tn7, r_td7;
    logic             r_sz7, r_tz7;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it7 <= r_it6;
            r_sz7 <= (r_sn6 < 0) || (r_sn6 < n_lim) || (r_sd6 <= 0);
            r_tz7 <= (r_tn6 < 0) || (r_tn6 < n_lim) || (r_td6 <= 0);
            r_sn7 <= (r_sd6 < r_sn6) ? r_sd6[DIV_W-1:0] : r_sn6[DIV_W-1:0];
            r_tn7 <= (r_td6 < r_tn6) ? r_td6[DIV_W-1:0] : r_tn6[DIV_W-1:0];
            r_sd7 <= r_sd6[DIV_W-1:0];
            r_td7 <= r_td6[DIV_W-1:0];
        end
    end

    logic [Q_W-1:0] w_sc, w_tc;

    ssd_div u_div_s (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r_sn7),
        .i_den  (r_sd7),
        .i_zero (r_sz7),
        .o_quot (w_sc)
    );

    ssd_div u_div_t (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r_tn7),
        .i_den  (r_td7),
        .i_zero (r_tz7),
        .o_quot (w_tc)
    );

    // hold the vectors alongside the dividers
    logic  r_vdiv [DIV_STAGES];
    t_item r_itdiv [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_itdiv[0] <= r_it7;
            for (int j = 1; j < DIV_STAGES; j++) begin
                r_itdiv[j] <= r_itdiv[j-1];
            end
        end
    end

    // closest points difference: w*2^32 + sc*u - tc*v
    logic                     r_v8;
    t_diff                    r_w8 [3];
    logic signed [PVEC_W-1:0] r_su8 [3];
    logic signed [PVEC_W-1:0] r_tv8 [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_w8[i]  <= r_itdiv[DIV_STAGES-1].w[i];
                r_su8[i] <= $signed({1'b0, w_sc}) * $signed(r_itdiv[DIV_STAGES-1].u[i]);
                r_tv8[i] <= $signed({1'b0, w_tc}) * $signed(r_itdiv[DIV_STAGES-1].v[i]);
            end
        end
    end

    logic                     r_v9;
    logic signed [PVEC_W-1:0] r_p9 [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_p9[i] <= (PVEC_W'(r_w8[i]) <<< FRAC_W) + r_su8[i] - r_tv8[i];
            end
        end
    end

    // squares of the difference components, split like the products above
    logic  r_v10;
    t_part r_pt10 [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_pt10[i] <= part_mul(r_p9[i], r_p9[i]);
            end
        end
    end

    logic            r_vp2;
    logic [SQ_W-1:0] r_p2 [3];
    t_wide           n_p2 [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_p2[i] = part_sum(r_pt10[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_p2[i] <= n_p2[i][SQ_W-1:0];
            end
        end
    end

    logic            r_v11;
    logic [SQ_W-1:0] r_sq11;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq11 <= r_p2[0] + r_p2[1] + r_p2[2];
        end
    end

    logic [ROOT_W-1:0] w_root;

    ssd_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sq   (r_sq11),
        .o_root (w_root)
    );

    logic              r_vsq [SQRT_STAGES];
    logic              r_out_valid;
    logic [DIST_W-1:0] r_dist;

    // valid flags of every stage advance together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_vpr       <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_v6        <= 1'b0;
            r_v7        <= 1'b0;
            r_v8        <= 1'b0;
            r_v9        <= 1'b0;
            r_v10       <= 1'b0;
            r_vp2       <= 1'b0;
            r_v11       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < DIV_STAGES; j++) begin
                r_vdiv[j] <= 1'b0;
            end
            for (int j = 0; j < SQRT_STAGES; j++) begin
                r_vsq[j] <= 1'b0;
            end
        end else if (en) begin
            r_v1      <= !i_empty;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_vpr     <= r_v3;
            r_v4      <= r_vpr;
            r_v5      <= r_v4;
            r_v6      <= r_v5;
            r_v7      <= r_v6;
            r_vdiv[0] <= r_v7;
            for (int j = 1; j < DIV_STAGES; j++) begin
                r_vdiv[j] <= r_vdiv[j-1];
            end
            r_v8     <= r_vdiv[DIV_STAGES-1];
            r_v9     <= r_v8;
            r_v10    <= r_v9;
            r_vp2    <= r_v10;
            r_v11    <= r_vp2;
            r_vsq[0] <= r_v11;
            for (int j = 1; j < SQRT_STAGES; j++) begin
                r_vsq[j] <= r_vsq[j-1];
            end
            r_out_valid <= r_vsq[SQRT_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (w_root[ROOT_W-1:FRAC_W+DIST_W] != '0) begin
                r_dist <= '1;
            end else begin
                r_dist <= w_root[FRAC_W+DIST_W-1:FRAC_W];
            end
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.closest_distance = r_dist;
endmodule
`default_nettype wire

// ===== sv/segment_segment_distance_3d.sv =====
`default_nettype none
// Shortest distance between two 3D segments, exact fixed point. Each input beat carries the
// two segments as twelve signed Q16.16 endpoints (only the low COORD_BITS bits of each are
// used); each output beat carries the distance as unsigned Q17.16, truncated. One pair is
// accepted every cycle unless the output stalls, and results leave in input order. A pair
// passes the four-entry queue, eight arithmetic stages (the wide second-order products take
// two of them), a 33-stage radix-2 divider for each line parameter, five stages that form
// the squared difference vector, a 67-stage square root that settles one result bit per
// stage, and the output register. near_zero_limit (reset 1) is written through i_cfg_we /
// i_cfg_wdata and should only change while no pair is in flight.
module segment_segment_distance_3d #(
    parameter int COORD_BITS = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    ssd_in_if.sink                        i_in,
    ssd_out_if.source                     o_out,
    input  wire logic                     i_cfg_we,
    input  wire logic [ssd_pkg::LIM_W-1:0] i_cfg_wdata
);
    import ssd_pkg::*;

    logic [LIM_W-1:0] r_near_zero_limit;

    // configuration register: take the write on any enabled edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_zero_limit <= LIM_RESET;
        end else if (i_cfg_we) begin
            r_near_zero_limit <= i_cfg_wdata;
        end
    end

    logic  front_valid;
    t_item front_item;
    logic  fifo_full;
    logic  fifo_empty;
    logic  fifo_pop;
    t_item fifo_item;
    logic  push;

    // advance the front beat into the queue whenever there is room
    assign push = front_valid && !fifo_full;

    ssd_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (front_valid),
        .o_item  (front_item),
        .i_take  (push)
    );

    // short queue lets the front keep taking beats while the back end holds
    ssd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .o_full  (fifo_full),
        .i_pop   (fifo_pop),
        .o_data  (fifo_item),
        .o_empty (fifo_empty)
    );

    // back end: dot products, clamping, division, square root
    ssd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lim   (r_near_zero_limit),
        .i_empty (fifo_empty),
        .i_item  (fifo_item),
        .o_pop   (fifo_pop),
        .o_out   (o_out)
    );
endmodule
`default_nettype wire
